// File: rtl/spq_pkg.sv
// Shared constants, codes and types for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY   = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int VALUE_W    = 32;
    localparam int PRIO_W     = 16;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } spq_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
// One entry slot of the sorted chain: holds a value and priority, shifts with its neighbors.
module spq_cell (
    input  logic                                clk,
    input  spq_pkg::spq_ctrl_t                  ctrl,
    input  logic                                occupied,
    input  logic signed [spq_pkg::VALUE_W-1:0]  new_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   new_prio,
    input  logic                                left_ge,
    input  logic signed [spq_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   left_prio,
    input  logic signed [spq_pkg::VALUE_W-1:0]  right_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   right_prio,
    output logic                                self_ge,
    output logic signed [spq_pkg::VALUE_W-1:0]  value,
    output logic signed [spq_pkg::PRIO_W-1:0]   prio
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic signed [PRIO_W-1:0]  prio_reg;
    logic signed [PRIO_W-1:0]  prio_next;

    assign self_ge = occupied && (prio_reg >= new_prio);

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.pop)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
        else if (ctrl.push && !self_ge)
        begin
            if (left_ge)
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            else
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, entry count and result register.
// Bounded priority queue of spq_pkg::CAPACITY entries, highest priority at the head, equal
// priorities in arrival order. Raise start with func, item_value and priority_req; busy stays
// low, so one push or pop is taken every cycle. Each operation gives exactly one result word
// in the next cycle, marked by done for a single cycle; the receiver cannot stall it. The rate
// is set by the row of compare-and-shift cells, which all move in the same cycle. A pop on an
// empty queue reports an empty error, a push on a full queue reports a full error and drops
// the word; neither changes the queue.
module sorted_priority_queue (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 func,
    input  logic signed [spq_pkg::VALUE_W-1:0]   item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]    priority_req,
    output logic                                 done,
    output logic [spq_pkg::STATUS_W-1:0]         status,
    output logic                                 head_valid,
    output logic signed [spq_pkg::VALUE_W-1:0]   head_value,
    output logic [spq_pkg::COUNT_W-1:0]          entry_count
);
    import spq_pkg::*;

    logic                      accept;
    logic                      is_pop;
    logic                      is_full;
    logic                      is_empty;
    spq_ctrl_t                 ctrl;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    status_t                   status_reg;
    status_t                   status_next;

    logic                      occ      [CAPACITY];
    logic                      ge       [CAPACITY];
    logic signed [VALUE_W-1:0] cell_val [CAPACITY];
    logic signed [PRIO_W-1:0]  cell_pri [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_pop   = (func == FUNC_POP);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        ctrl.push   = accept && !is_pop && !is_full;
        ctrl.pop    = accept && is_pop && !is_empty;
        count_next  = count_reg;
        status_next = ST_OK;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (is_pop && is_empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (!is_pop && is_full)
        begin
            status_next = ST_FULL;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                      l_ge;
            logic signed [VALUE_W-1:0] l_val;
            logic signed [PRIO_W-1:0]  l_pri;
            logic signed [VALUE_W-1:0] r_val;
            logic signed [PRIO_W-1:0]  r_pri;

            assign occ[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign l_ge  = 1'b1;
                assign l_val = '0;
                assign l_pri = '0;
            end
            else
            begin : g_mid
                assign l_ge  = ge[i-1];
                assign l_val = cell_val[i-1];
                assign l_pri = cell_pri[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign r_val = '0;
                assign r_pri = '0;
            end
            else
            begin : g_inner
                assign r_val = cell_val[i+1];
                assign r_pri = cell_pri[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ[i]),
                .new_value   (item_value),
                .new_prio    (priority_req),
                .left_ge     (l_ge),
                .left_value  (l_val),
                .left_prio   (l_pri),
                .right_value (r_val),
                .right_prio  (r_pri),
                .self_ge     (ge[i]),
                .value       (cell_val[i]),
                .prio        (cell_pri[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign head_valid  = (count_reg != '0);
    assign head_value  = head_valid ? cell_val[0] : '0;
    assign entry_count = COUNT_W'(count_reg);

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result strobe without accepted word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_pop && !is_full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not add an entry");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (!head_valid && head_value == '0))
        else $error("empty error with a head shown");

endmodule

// File: sim/tb.sv
// Testbench for the sorted priority queue: scoreboard class, word drivers and result checks.
module tb;
    import spq_pkg::*;

    localparam int IDLE_LIMIT = 200;

    class queue_mirror;
        typedef struct {
            logic [STATUS_W-1:0]        status;
            logic                       head_valid;
            logic signed [VALUE_W-1:0]  head_value;
            logic [COUNT_W-1:0]         entry_count;
        } result_word_t;

        logic signed [VALUE_W-1:0] values[CAPACITY];
        logic signed [PRIO_W-1:0]  prios[CAPACITY];
        int                        held;
        int                        errors;
        result_word_t              expected_words[$];

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        function void note_word(func_t op, logic signed [VALUE_W-1:0] value,
                                logic signed [PRIO_W-1:0] prio);
            result_word_t w;
            status_t      st;
            int           pos;
            st = ST_OK;
            if (op == FUNC_POP)
            begin
                if (held == 0)
                    st = ST_EMPTY;
                else
                begin
                    for (int i = 1; i < held; i++)
                    begin
                        values[i-1] = values[i];
                        prios[i-1]  = prios[i];
                    end
                    held--;
                end
            end
            else if (held >= CAPACITY)
                st = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < held && prios[pos] >= prio)
                    pos++;
                for (int i = held; i > pos; i--)
                begin
                    values[i] = values[i-1];
                    prios[i]  = prios[i-1];
                end
                values[pos] = value;
                prios[pos]  = prio;
                held++;
            end
            w.status      = st;
            w.head_valid  = (held != 0);
            w.head_value  = (held != 0) ? values[0] : '0;
            w.entry_count = COUNT_W'(held);
            expected_words.push_back(w);
        endfunction

        task check_word(logic [STATUS_W-1:0] st, logic hv, logic [VALUE_W-1:0] hval,
                        logic [COUNT_W-1:0] cnt);
            result_word_t w;
            if (expected_words.size() == 0)
            begin
                report("result word with no operation outstanding");
                return;
            end
            w = expected_words.pop_front();
            if (st !== w.status)
                report($sformatf("status got %0d expected %0d", st, w.status));
            if (hv !== w.head_valid)
                report($sformatf("head_valid got %0b expected %0b", hv, w.head_valid));
            if (hval !== w.head_value)
                report($sformatf("head_value got %h expected %h", hval, w.head_value));
            if (cnt !== w.entry_count)
                report($sformatf("entry_count got %0d expected %0d", cnt, w.entry_count));
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    func_t                      func;
    logic signed [VALUE_W-1:0]  item_value;
    logic signed [PRIO_W-1:0]   priority_req;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic                       head_valid;
    logic signed [VALUE_W-1:0]  head_value;
    logic [COUNT_W-1:0]         entry_count;

    queue_mirror mirror;
    int          idle_cycles;

    sorted_priority_queue u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .item_value   (item_value),
        .priority_req (priority_req),
        .done         (done),
        .status       (status),
        .head_valid   (head_valid),
        .head_value   (head_value),
        .entry_count  (entry_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (start && !busy)
            begin
                mirror.note_word(func, item_value, priority_req);
                moved = 1'b1;
            end
            if (done)
            begin
                mirror.check_word(status, head_valid, head_value, entry_count);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task idle(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task send_word(func_t op, logic signed [VALUE_W-1:0] value,
                   logic signed [PRIO_W-1:0] prio);
        @(negedge clk);
        start        <= 1'b1;
        func         <= op;
        item_value   <= value;
        priority_req <= prio;
        do
            @(posedge clk);
        while (busy);
    endtask

    task push(logic signed [VALUE_W-1:0] value, logic signed [PRIO_W-1:0] prio);
        send_word(FUNC_PUSH, value, prio);
    endtask

    task pop();
        send_word(FUNC_POP, $urandom, PRIO_W'($urandom));
    endtask

    task random_words(int total, bit with_gaps);
        int                         sent;
        int                         seg_len;
        int                         push_pct;
        int                         prio_mode;
        bit                         gaps_on;
        func_t                      op;
        logic signed [PRIO_W-1:0]   prio;
        sent = 0;
        while (sent < total)
        begin
            seg_len   = $urandom_range(16, 48);
            prio_mode = $urandom_range(0, 2);
            gaps_on   = with_gaps && ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 4))
                0:       push_pct = 15;
                1, 2:    push_pct = 50;
                3:       push_pct = 85;
                default: push_pct = 97;
            endcase
            for (int k = 0; k < seg_len && sent < total; k++)
            begin
                op = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
                case (prio_mode)
                    0:       prio = PRIO_W'($urandom);
                    1:       prio = PRIO_W'(int'($urandom_range(0, 4)) - 2);
                    default: prio = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                endcase
                send_word(op, $urandom, prio);
                sent++;
                if (gaps_on && $urandom_range(0, 5) == 0)
                    idle($urandom_range(1, 12));
            end
        end
    endtask

    initial
    begin
        mirror       = new();
        idle_cycles  = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FUNC_PUSH;
        item_value   = '0;
        priority_req = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        pop();
        push(32'sh0, 16'sh0);
        pop();
        pop();
        push(32'sh7fffffff, 16'sh7fff);
        push(32'sh80000000, 16'sh8000);
        push(32'shffffffff, -16'sd1);
        push(32'sh55555555, 16'sh0);
        push(32'shaaaaaaaa, 16'sh0);
        push(32'sh00000001, 16'sh0);
        push(32'sh00000002, 16'sh7fff);
        repeat (8) pop();

        random_words(1250, 1'b1);
        random_words(200, 1'b0);

        @(negedge clk);
        start <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
